@@ hdl/ymsc_pkg.sv @@
// Package with the phase, action, opcode and byte codes of the YMODEM sender control.
package ymsc_pkg;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_HEADER  = 6'b000010,
    PH_DATA    = 6'b000100,
    PH_TRAILER = 6'b001000,
    PH_DONE    = 6'b010000,
    PH_CANCEL  = 6'b100000
  } phase_e;

  localparam logic [2:0] PHC_IDLE    = 3'd0;
  localparam logic [2:0] PHC_HEADER  = 3'd1;
  localparam logic [2:0] PHC_DATA    = 3'd2;
  localparam logic [2:0] PHC_TRAILER = 3'd3;
  localparam logic [2:0] PHC_DONE    = 3'd4;
  localparam logic [2:0] PHC_CANCEL  = 3'd5;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_HEADER  = 3'd1;
  localparam logic [2:0] ACT_DATA    = 3'd2;
  localparam logic [2:0] ACT_EOT     = 3'd3;
  localparam logic [2:0] ACT_TRAILER = 3'd4;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  localparam logic [7:0] BYTE_C   = 8'h43;
  localparam logic [7:0] BYTE_NAK = 8'h15;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_EOT = 8'h04;

  localparam int unsigned CountWidth = 16;

  typedef struct packed {
    logic [2:0]            action;
    logic [CountWidth-1:0] packet_index;
    logic [2:0]            phase;
  } result_t;

  function automatic logic [2:0] phase_code(phase_e ph);
    logic [2:0] code;
    case (ph)
      PH_IDLE:    code = PHC_IDLE;
      PH_HEADER:  code = PHC_HEADER;
      PH_DATA:    code = PHC_DATA;
      PH_TRAILER: code = PHC_TRAILER;
      PH_DONE:    code = PHC_DONE;
      PH_CANCEL:  code = PHC_CANCEL;
      default:    code = PHC_IDLE;
    endcase
    return code;
  endfunction

endpackage

@@ hdl/ymodem_sender_control_unit.sv @@
// YMODEM sender control: phase sequencing, handshake flags and packet progress.
// Each transfer updates the state in the cycle it is accepted; its result is registered
// in the output register, or in the skid stage while the output is stalled.
// A new item is accepted every cycle while the skid stage is empty; a skid stage behind
// the output register keeps intake going for one item while a result waits under stall.
// Reset clears the phase to idle, the flags, the packet count and the frame count.
module ymodem_sender_control_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     opcode_i,
  input  logic [7:0]                     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     action_o,
  output logic [ymsc_pkg::CountWidth-1:0] packet_index_o,
  output logic [2:0]                     phase_o,
  input  logic                           cfg_we_i,
  input  logic [ymsc_pkg::CountWidth-1:0] cfg_data_i
);
  import ymsc_pkg::*;

  phase_e                phase_q, phase_d;
  logic                  header_sent_q, header_sent_d;
  logic                  header_acked_q, header_acked_d;
  logic                  trailer_armed_q, trailer_armed_d;
  logic [CountWidth-1:0] acked_q, acked_d;
  logic [CountWidth-1:0] frame_count_q;
  logic [CountWidth-1:0] acked_inc;
  logic [2:0]            action;
  logic                  active;
  result_t               res_new;
  result_t               out_q, skid_q;
  logic                  out_valid_q, skid_valid_q;
  logic                  in_fire, out_free;

  assign active    = (phase_q == PH_HEADER) || (phase_q == PH_DATA) ||
                     (phase_q == PH_TRAILER);
  assign acked_inc = (acked_q == {CountWidth{1'b1}}) ? acked_q : acked_q + 1'b1;

  always_comb begin
    phase_d         = phase_q;
    header_sent_d   = header_sent_q;
    header_acked_d  = header_acked_q;
    trailer_armed_d = trailer_armed_q;
    acked_d         = acked_q;
    action          = ACT_NONE;
    case (opcode_i)
      OP_START: begin
        phase_d         = PH_HEADER;
        header_sent_d   = 1'b0;
        header_acked_d  = 1'b0;
        trailer_armed_d = 1'b0;
        acked_d         = '0;
      end
      OP_STOP: begin
        if (active) begin
          phase_d = PH_CANCEL;
        end
      end
      OP_BYTE: begin
        if (active) begin
          if (rx_byte_i == BYTE_EOT) begin
            phase_d = PH_CANCEL;
          end else begin
            case (phase_q)
              PH_HEADER: begin
                if (rx_byte_i == BYTE_C) begin
                  if (!header_sent_q) begin
                    header_sent_d = 1'b1;
                    action        = ACT_HEADER;
                  end else if (header_acked_q) begin
                    if (frame_count_q == '0) begin
                      phase_d = PH_TRAILER;
                      action  = ACT_EOT;
                    end else begin
                      phase_d = PH_DATA;
                      action  = ACT_DATA;
                    end
                  end
                end else if (rx_byte_i == BYTE_NAK) begin
                  if (header_sent_q) begin
                    action = ACT_HEADER;
                  end
                end else if (rx_byte_i == BYTE_ACK) begin
                  if (header_sent_q) begin
                    header_acked_d = 1'b1;
                  end
                end
              end
              PH_DATA: begin
                if (rx_byte_i == BYTE_ACK) begin
                  acked_d = acked_inc;
                  if (acked_inc < frame_count_q) begin
                    action = ACT_DATA;
                  end else begin
                    phase_d = PH_TRAILER;
                    action  = ACT_EOT;
                  end
                end else if (rx_byte_i == BYTE_NAK) begin
                  action = ACT_DATA;
                end
              end
              PH_TRAILER: begin
                if (rx_byte_i == BYTE_C) begin
                  if (trailer_armed_q) begin
                    action = ACT_TRAILER;
                  end
                end else if (rx_byte_i == BYTE_NAK) begin
                  action = ACT_EOT;
                end else if (rx_byte_i == BYTE_ACK) begin
                  if (!trailer_armed_q) begin
                    trailer_armed_d = 1'b1;
                  end else begin
                    phase_d = PH_DONE;
                  end
                end
              end
              default: begin
                phase_d = phase_q;
              end
            endcase
          end
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  assign res_new.action       = action;
  assign res_new.packet_index = acked_d;
  assign res_new.phase        = phase_code(phase_d);

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      header_sent_q   <= 1'b0;
      header_acked_q  <= 1'b0;
      trailer_armed_q <= 1'b0;
      acked_q         <= '0;
      frame_count_q   <= '0;
      out_valid_q     <= 1'b0;
      skid_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frame_count_q <= cfg_data_i;
      end
      if (in_fire) begin
        phase_q         <= phase_d;
        header_sent_q   <= header_sent_d;
        header_acked_q  <= header_acked_d;
        trailer_armed_q <= trailer_armed_d;
        acked_q         <= acked_d;
      end
      if (skid_valid_q) begin
        if (out_free) begin
          skid_valid_q <= 1'b0;
          out_valid_q  <= 1'b1;
        end
      end else if (in_fire) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_free) begin
        out_q <= res_new;
      end else begin
        skid_q <= res_new;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = out_q.action;
  assign packet_index_o = out_q.packet_index;
  assign phase_o        = out_q.phase;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Skid entry is held while the output register is empty.");

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("Phase register is not one-hot.");

  a_idle_ignores_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (opcode_i == OP_BYTE) && (phase_q == PH_IDLE) |=> (phase_q == PH_IDLE))
    else $error("A received byte moved the block out of idle.");

  a_result_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("An accepted transfer produced no result.");

endmodule

@@ dv/ymodem_sender_control_unit_tb.sv @@
// Self-checking testbench for the YMODEM sender control unit, with directed and random files.
module ymodem_sender_control_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ymsc_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned LONG_HOLD = 60;
  localparam result_t NO_RESULT = '0;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [15:0] frames;
    logic [1:0]  op;
    logic [7:0]  rx;
    bit          typed;
    result_t     res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = OP_START;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  action_o;
  logic [CountWidth-1:0] packet_index_o;
  logic [2:0]  phase_o;
  logic        cfg_we_i = 1'b0;
  logic [CountWidth-1:0] cfg_data_i = '0;

  logic [2:0]  shadow_phase;
  logic        shadow_hdr_sent;
  logic        shadow_hdr_acked;
  logic        shadow_armed;
  logic [15:0] shadow_acked;
  logic [15:0] shadow_frames;

  result_t     expected_actions[$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned files_sent;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned hold_left;

  dir_row_t dir_table [28] = '{
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_C, 1'b1, '{ACT_NONE, 16'd0, PHC_IDLE}},
    '{ROW_ITEM, 16'd0, OP_STOP, 8'h00, 1'b1, '{ACT_NONE, 16'd0, PHC_IDLE}},
    '{ROW_ITEM, 16'd0, OP_RESERVED, 8'hFF, 1'b1, '{ACT_NONE, 16'd0, PHC_IDLE}},
    '{ROW_ITEM, 16'd0, OP_START, 8'hFF, 1'b1, '{ACT_NONE, 16'd0, PHC_HEADER}},
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_NAK, 1'b1, '{ACT_NONE, 16'd0, PHC_HEADER}},
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_ACK, 1'b1, '{ACT_NONE, 16'd0, PHC_HEADER}},
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_C, 1'b1, '{ACT_HEADER, 16'd0, PHC_HEADER}},
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_C, 1'b0, NO_RESULT},
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_ACK, 1'b0, NO_RESULT},
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_C, 1'b1, '{ACT_EOT, 16'd0, PHC_TRAILER}},
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_C, 1'b0, NO_RESULT},
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_ACK, 1'b0, NO_RESULT},
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_C, 1'b1, '{ACT_TRAILER, 16'd0, PHC_TRAILER}},
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_ACK, 1'b1, '{ACT_NONE, 16'd0, PHC_DONE}},
    '{ROW_ITEM, 16'd0, OP_STOP, 8'h00, 1'b1, '{ACT_NONE, 16'd0, PHC_DONE}},
    '{ROW_ITEM, 16'd0, OP_BYTE, 8'h00, 1'b1, '{ACT_NONE, 16'd0, PHC_DONE}},
    '{ROW_CFG, 16'd3, OP_START, 8'h00, 1'b0, NO_RESULT},
    '{ROW_ITEM, 16'd0, OP_START, 8'h00, 1'b0, NO_RESULT},
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_C, 1'b0, NO_RESULT},
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_ACK, 1'b0, NO_RESULT},
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_C, 1'b0, NO_RESULT},
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_ACK, 1'b0, NO_RESULT},
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_NAK, 1'b0, NO_RESULT},
    '{ROW_CFG, 16'd1, OP_START, 8'h00, 1'b0, NO_RESULT},
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_ACK, 1'b0, NO_RESULT},
    '{ROW_ITEM, 16'd0, OP_STOP, 8'h00, 1'b0, NO_RESULT},
    '{ROW_ITEM, 16'd0, OP_START, 8'h00, 1'b0, NO_RESULT},
    '{ROW_ITEM, 16'd0, OP_BYTE, BYTE_EOT, 1'b1, '{ACT_NONE, 16'd0, PHC_CANCEL}}
  };

  ymodem_sender_control_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_o       (action_o),
    .packet_index_o (packet_index_o),
    .phase_o        (phase_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t advance_sender(logic [1:0] op, logic [7:0] b);
    result_t    r;
    logic [2:0] act;
    logic       active;
    act = ACT_NONE;
    active = (shadow_phase == PHC_HEADER) || (shadow_phase == PHC_DATA) ||
             (shadow_phase == PHC_TRAILER);
    if (op == OP_START) begin
      shadow_phase = PHC_HEADER;
      shadow_hdr_sent = 1'b0;
      shadow_hdr_acked = 1'b0;
      shadow_armed = 1'b0;
      shadow_acked = '0;
    end else if (op == OP_STOP) begin
      if (active) shadow_phase = PHC_CANCEL;
    end else if (op == OP_BYTE && active) begin
      if (b == BYTE_EOT) begin
        shadow_phase = PHC_CANCEL;
      end else if (shadow_phase == PHC_HEADER) begin
        if (b == BYTE_C) begin
          if (!shadow_hdr_sent) begin
            shadow_hdr_sent = 1'b1;
            act = ACT_HEADER;
          end else if (shadow_hdr_acked) begin
            if (shadow_frames == 16'd0) begin
              shadow_phase = PHC_TRAILER;
              act = ACT_EOT;
            end else begin
              shadow_phase = PHC_DATA;
              act = ACT_DATA;
            end
          end
        end else if (b == BYTE_NAK) begin
          if (shadow_hdr_sent) act = ACT_HEADER;
        end else if (b == BYTE_ACK) begin
          if (shadow_hdr_sent) shadow_hdr_acked = 1'b1;
        end
      end else if (shadow_phase == PHC_DATA) begin
        if (b == BYTE_ACK) begin
          if (shadow_acked != 16'hFFFF) shadow_acked = shadow_acked + 16'd1;
          if (shadow_acked < shadow_frames) begin
            act = ACT_DATA;
          end else begin
            shadow_phase = PHC_TRAILER;
            act = ACT_EOT;
          end
        end else if (b == BYTE_NAK) begin
          act = ACT_DATA;
        end
      end else begin
        if (b == BYTE_C) begin
          if (shadow_armed) act = ACT_TRAILER;
        end else if (b == BYTE_NAK) begin
          act = ACT_EOT;
        end else if (b == BYTE_ACK) begin
          if (!shadow_armed) shadow_armed = 1'b1;
          else shadow_phase = PHC_DONE;
        end
      end
    end
    r.action = act;
    r.packet_index = shadow_acked;
    r.phase = shadow_phase;
    return r;
  endfunction

  task automatic offer(logic [1:0] op, logic [7:0] b, bit typed, result_t typed_res);
    result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = advance_sender(op, b);
    expected_actions.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  task automatic offer_rx(logic [7:0] b);
    offer(OP_BYTE, b, 1'b0, NO_RESULT);
  endtask

  task automatic line_noise();
    if ($urandom_range(7) == 0) begin
      if ($urandom_range(7) == 0) begin
        offer(2'($urandom_range(3)), 8'($urandom_range(255)), 1'b0, NO_RESULT);
      end else begin
        offer_rx(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic abort_file();
    if ($urandom_range(1) == 0) begin
      offer(OP_STOP, 8'($urandom_range(255)), 1'b0, NO_RESULT);
    end else begin
      offer_rx(BYTE_EOT);
    end
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (expected_actions.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_frames(logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_frames = value;
  endtask

  task automatic send_file(logic [15:0] frames);
    int unsigned abort_stage;
    int unsigned n;
    abort_stage = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
    offer(OP_START, 8'($urandom_range(255)), 1'b0, NO_RESULT);
    if ($urandom_range(3) == 0) offer_rx(BYTE_NAK);
    offer_rx(BYTE_C);
    line_noise();
    if ($urandom_range(3) == 0) offer_rx(BYTE_C);
    if ($urandom_range(3) == 0) offer_rx(BYTE_NAK);
    offer_rx(BYTE_ACK);
    line_noise();
    if (abort_stage == 1) begin
      abort_file();
      return;
    end
    offer_rx(BYTE_C);
    n = (frames > 16'd8) ? $urandom_range(1, 6) : frames;
    for (int i = 0; i < n; i++) begin
      line_noise();
      if ($urandom_range(3) == 0) offer_rx(BYTE_NAK);
      offer_rx(BYTE_ACK);
    end
    if (abort_stage == 2 || frames > 16'd8) begin
      abort_file();
      return;
    end
    if ($urandom_range(2) == 0) offer_rx(BYTE_NAK);
    if ($urandom_range(2) == 0) offer_rx(BYTE_C);
    offer_rx(BYTE_ACK);
    if (abort_stage == 3) begin
      abort_file();
      return;
    end
    offer_rx(BYTE_C);
    offer_rx(BYTE_ACK);
    line_noise();
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      out_stall_i <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_served <= hold_served + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_actions.size() == 0) begin
        errors++;
        $display("%t: unexpected result, got action %0d index %0d phase %0d", $time,
                 action_o, packet_index_o, phase_o);
      end else begin
        exp_r = expected_actions.pop_front();
        if (action_o !== exp_r.action) begin
          errors++;
          $display("%t: action expected %0d, got %0d", $time, exp_r.action, action_o);
        end
        if (packet_index_o !== exp_r.packet_index) begin
          errors++;
          $display("%t: packet_index expected %0d, got %0d", $time, exp_r.packet_index,
                   packet_index_o);
        end
        if (phase_o !== exp_r.phase) begin
          errors++;
          $display("%t: phase expected %0d, got %0d", $time, exp_r.phase, phase_o);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (rst_ni && !((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) begin
        quiet++;
      end else begin
        quiet = 0;
      end
    end
    $display("%t: timeout, no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("ymodem_sender_control_unit: mismatch");
    $finish;
  end

  initial begin
    int unsigned base;
    int unsigned mode;
    int unsigned pick;
    logic [15:0] frames;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    files_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    shadow_phase = PHC_IDLE;
    shadow_hdr_sent = 1'b0;
    shadow_hdr_acked = 1'b0;
    shadow_armed = 1'b0;
    shadow_acked = '0;
    shadow_frames = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        wait_results_drained();
        write_frames(dir_table[i].frames);
      end else begin
        offer(dir_table[i].op, dir_table[i].rx, dir_table[i].typed, dir_table[i].res);
      end
    end

    base = items_sent;
    while (items_sent < base + RANDOM_ITEMS) begin
      mode = (items_sent - base) * 4 / RANDOM_ITEMS;
      wait_results_drained();
      case (mode)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 80;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 80;
        end
        default: begin
          idle_pct = 27;
          stall_pct = 27;
        end
      endcase
      pick = $urandom_range(9);
      if (pick == 0) frames = 16'd0;
      else if (pick == 1) frames = 16'hFFFF;
      else if (pick == 2) frames = 16'($urandom_range(65535));
      else frames = 16'($urandom_range(1, 6));
      write_frames(frames);
      if (files_sent == 2 || files_sent == 25) hold_requests++;
      send_file(frames);
      files_sent++;
    end

    wait_results_drained();
    repeat (4) @(posedge clk_i);
    if (expected_actions.size() != 0) begin
      errors++;
      $display("%t: %0d expected results never arrived", $time, expected_actions.size());
    end
    $display("Sent %0d events over %0d random files plus the directed table,", items_sent,
             files_sent);
    $display("checked %0d results under four idling patterns, %0d errors.", results_seen,
             errors);
    if (errors == 0) begin
      $display("ymodem_sender_control_unit: match");
    end else begin
      $display("ymodem_sender_control_unit: mismatch");
    end
    $finish;
  end

endmodule
